@@ design/neighbour_difference_edge_detect_assert.svh @@
// Assertion macros for the neighbour-difference edge detector.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef NEIGHBOUR_DIFFERENCE_EDGE_DETECT_ASSERT_SVH
`define NEIGHBOUR_DIFFERENCE_EDGE_DETECT_ASSERT_SVH

// Same-cycle implication.
`define NDEDGE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NDEDGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ndedge_pkg.sv @@
// Shared types and constants for the neighbour-difference edge detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ndedge_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHAN_W        = 8;
  localparam int IMG_W         = 11;
  localparam int APB_AW        = 4;
  localparam int APB_DW        = 32;

  // Neighbour select codes
  localparam logic [1:0] DIR_RIGHT       = 2'd0;
  localparam logic [1:0] DIR_BELOW       = 2'd1;
  localparam logic [1:0] DIR_BELOW_RIGHT = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;

  // Beat kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Reset values
  localparam logic [1:0]        DIR_RST   = DIR_BELOW_RIGHT;
  localparam logic [CHAN_W-1:0] THR_RST   = 8'd5;
  localparam logic [IMG_W-1:0]  WIDTH_RST = 11'd640;

  typedef struct packed {
    logic [1:0]        direction;
    logic [CHAN_W-1:0] threshold;
    logic [IMG_W-1:0]  width;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Decision issued when a beat is taken; ring data follows in the next cycle.
  typedef struct packed {
    logic valid;     // beat retires the oldest queued pixel
    logic has_nb;    // neighbour lies inside the image
    logic nb_is_px;  // neighbour is the incoming pixel, not a ring entry
    rgb_t px;        // incoming pixel
  } dec_t;

endpackage

`default_nettype wire

@@ design/ndedge_pix_if.sv @@
// Input channel: pixel or flush beats.
// Depends on ndedge_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ndedge_pix_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [ndedge_pkg::CHAN_W-1:0] red_in;
  logic [ndedge_pkg::CHAN_W-1:0] green_in;
  logic [ndedge_pkg::CHAN_W-1:0] blue_in;

  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

@@ design/ndedge_res_if.sv @@
// Result channel: one edge decision per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ndedge_res_if;
  logic valid;
  logic ready;
  logic edge_found;

  modport source (output valid, edge_found, input ready);
  modport sink   (input valid, edge_found, output ready);
endinterface

`default_nettype wire

@@ design/ndedge_regs.sv @@
// APB configuration registers: direction, threshold, image width.
// Depends on ndedge_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ndedge_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ndedge_pkg::APB_AW-1:0] paddr,
  input  wire logic [ndedge_pkg::APB_DW-1:0] pwdata,
  output logic      [ndedge_pkg::APB_DW-1:0] prdata,
  output logic                               pready,
  output ndedge_pkg::cfg_t                   cfg
);

  ndedge_pkg::cfg_t cfg_r, cfg_nxt;
  logic             wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (paddr[3:2])
        ndedge_pkg::REG_DIRECTION: cfg_nxt.direction = pwdata[1:0];
        ndedge_pkg::REG_THRESHOLD: cfg_nxt.threshold = pwdata[ndedge_pkg::CHAN_W-1:0];
        ndedge_pkg::REG_WIDTH:     cfg_nxt.width     = pwdata[ndedge_pkg::IMG_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction <= ndedge_pkg::DIR_RST;
      cfg_r.threshold <= ndedge_pkg::THR_RST;
      cfg_r.width     <= ndedge_pkg::WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      ndedge_pkg::REG_DIRECTION: prdata = ndedge_pkg::APB_DW'(cfg_r.direction);
      ndedge_pkg::REG_THRESHOLD: prdata = ndedge_pkg::APB_DW'(cfg_r.threshold);
      ndedge_pkg::REG_WIDTH:     prdata = ndedge_pkg::APB_DW'(cfg_r.width);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/ndedge_ring.sv @@
// Pixel ring buffer: one write port, two registered read ports.
// Depends on ndedge_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

module ndedge_ring #(
  parameter int DEPTH = ndedge_pkg::MAX_WIDTH_DEF + 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr_a,
  input  wire logic [AW-1:0]     rd_addr_b,
  output ndedge_pkg::rgb_t       rd_data_a,
  output ndedge_pkg::rgb_t       rd_data_b,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire ndedge_pkg::rgb_t  wr_data
);

  ndedge_pkg::rgb_t mem [DEPTH];
  ndedge_pkg::rgb_t rd_a_r, rd_b_r;

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

@@ design/ndedge_ctrl.sv @@
// Queue control: ring head, fill count and column tracking; issues ring
// accesses and the retire decision for each accepted beat. Depends on ndedge_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ndedge_ctrl #(
  parameter int MAX_WIDTH = ndedge_pkg::MAX_WIDTH_DEF,
  parameter int RING      = MAX_WIDTH + 1,
  parameter int AW        = $clog2(RING),
  parameter int CNT_W     = $clog2(MAX_WIDTH + 2)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ndedge_pkg::cfg_t cfg,
  input  wire logic          acc,
  input  wire logic          func,
  input  wire ndedge_pkg::rgb_t px,
  output logic [AW-1:0]      rd_addr_a,
  output logic [AW-1:0]      rd_addr_b,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output ndedge_pkg::dec_t   dec,
  output logic [CNT_W-1:0]   count,
  output logic [CNT_W-1:0]   delay
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int XW    = CNT_W + 1;
  localparam int CMP_W = (CNT_W > ndedge_pkg::IMG_W) ? CNT_W : ndedge_pkg::IMG_W;

  logic [AW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [COL_W-1:0] old_col_r, old_col_nxt;
  logic [COL_W-1:0] new_col_r, new_col_nxt;

  logic [CMP_W-1:0] iw;
  logic [CNT_W-1:0] w, d;
  logic             is_flush, pop, nb_queued, col_ok, push;
  logic [CNT_W-1:0] count_pop;
  logic [COL_W-1:0] old_col_pop;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CNT_W-1:0] ofs);
    logic [XW-1:0] s;
    s = XW'(base) + XW'(ofs);
    if (s >= XW'(RING)) s = s - XW'(RING);
    return s[AW-1:0];
  endfunction

  function automatic logic [COL_W-1:0] col_step(input logic [COL_W-1:0] col,
                                                input logic [CNT_W-1:0] wid);
    logic [XW-1:0] c1;
    c1 = XW'(col) + XW'(1);
    if (c1 >= XW'(wid)) return '0;
    return c1[COL_W-1:0];
  endfunction

  // Effective width clamped to [2, MAX_WIDTH], then delay to the neighbour.
  always_comb begin
    iw = CMP_W'(cfg.width);
    if (iw < CMP_W'(2)) iw = CMP_W'(2);
    if (iw > CMP_W'(MAX_WIDTH)) iw = CMP_W'(MAX_WIDTH);
    w = iw[CNT_W-1:0];
    case (cfg.direction)
      ndedge_pkg::DIR_RIGHT: d = CNT_W'(1);
      ndedge_pkg::DIR_BELOW: d = w;
      default:               d = w + CNT_W'(1);
    endcase
  end

  always_comb begin
    is_flush  = (func == ndedge_pkg::FUNC_FLUSH);
    nb_queued = (d < count_r);
    pop       = is_flush ? (count_r != '0) : (count_r >= d);
    // Last column has no right-hand neighbour.
    col_ok    = !((cfg.direction != ndedge_pkg::DIR_BELOW) &&
                  (XW'(old_col_r) + XW'(1) >= XW'(w)));

    count_pop   = count_r - CNT_W'(pop);
    old_col_pop = pop ? col_step(old_col_r, w) : old_col_r;
    push        = !is_flush && (count_pop < CNT_W'(RING));

    dec.valid    = acc && pop;
    dec.has_nb   = col_ok && (nb_queued || !is_flush);
    dec.nb_is_px = !is_flush && !nb_queued;
    dec.px       = px;

    rd_addr_a = head_r;
    rd_addr_b = ring_add(head_r, d);
    wr_addr   = ring_add(head_r, count_r);
    wr_en     = acc && push;

    head_nxt    = head_r;
    count_nxt   = count_r;
    old_col_nxt = old_col_r;
    new_col_nxt = new_col_r;
    if (acc) begin
      if (pop) head_nxt = (head_r == AW'(RING - 1)) ? '0 : head_r + AW'(1);
      if (is_flush) begin
        count_nxt   = count_pop;
        old_col_nxt = old_col_pop;
        if (count_pop == '0) begin
          old_col_nxt = '0;
          new_col_nxt = '0;
        end
      end else begin
        count_nxt   = count_pop + CNT_W'(push);
        old_col_nxt = (count_nxt == CNT_W'(1)) ? new_col_r : old_col_pop;
        new_col_nxt = col_step(new_col_r, w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      old_col_r <= '0;
      new_col_r <= '0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      old_col_r <= old_col_nxt;
      new_col_r <= new_col_nxt;
    end
  end

  assign count = count_r;
  assign delay = d;

endmodule

`default_nettype wire

@@ design/ndedge_out.sv @@
// Compare stage and result register: checks the three channel differences
// against the threshold and holds the result beat. Depends on ndedge_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ndedge_out (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [ndedge_pkg::CHAN_W-1:0] threshold,
  input  wire logic                          acc,
  input  wire ndedge_pkg::dec_t              dec,
  input  wire ndedge_pkg::rgb_t              rd_px,
  input  wire ndedge_pkg::rgb_t              rd_nb,
  output logic                               take_ok,
  ndedge_res_if.source                       res
);

  localparam int SW = ndedge_pkg::CHAN_W + 1;

  logic             s1_valid_r, s1_valid_nxt;
  ndedge_pkg::dec_t s1_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_edge_r;
  logic             advance;
  ndedge_pkg::rgb_t nb;
  logic             hit;

  // nb - px > thr, kept unsigned as nb > px + thr
  function automatic logic over(input logic [ndedge_pkg::CHAN_W-1:0] n,
                                input logic [ndedge_pkg::CHAN_W-1:0] p,
                                input logic [ndedge_pkg::CHAN_W-1:0] t);
    return SW'(n) > (SW'(p) + SW'(t));
  endfunction

  assign advance = !out_valid_r || res.ready;
  assign take_ok = !s1_valid_r || advance;

  always_comb begin
    nb  = s1_r.nb_is_px ? s1_r.px : rd_nb;
    hit = s1_r.has_nb && (over(nb.red,   rd_px.red,   threshold) ||
                          over(nb.green, rd_px.green, threshold) ||
                          over(nb.blue,  rd_px.blue,  threshold));

    s1_valid_nxt = s1_valid_r;
    if (take_ok) s1_valid_nxt = acc && dec.valid;

    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) s1_r <= dec;
    if (advance && s1_valid_r) out_edge_r <= hit;
  end

  assign res.valid      = out_valid_r;
  assign res.edge_found = out_edge_r;

endmodule

`default_nettype wire

@@ design/neighbour_difference_edge_detect.sv @@
// Neighbour-difference edge detector, top level.
// Throughput: one beat per cycle while the input is not stalled; each beat reads
// the ring once at two addresses. A retiring beat's result goes through the ring
// read register, then the compare into the result register; a pixel retires only
// once its neighbour has arrived, i.e. 1, W or W+1 pixels later, or on flush.
// Reset: registers to defaults, queue empty; the ring is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "neighbour_difference_edge_detect_assert.svh"

module neighbour_difference_edge_detect #(
  parameter int MAX_WIDTH = ndedge_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ndedge_pix_if.sink                         in_if,
  ndedge_res_if.source                       out_if,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ndedge_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [ndedge_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [ndedge_pkg::APB_DW-1:0] cfg_prdata,
  output logic                               cfg_pready
);

  // Ring holds a full row plus one pixel (below-right neighbour distance).
  localparam int RING  = MAX_WIDTH + 1;
  localparam int AW    = $clog2(RING);
  localparam int CNT_W = $clog2(MAX_WIDTH + 2);

  ndedge_pkg::cfg_t cfg;
  ndedge_pkg::dec_t dec;
  ndedge_pkg::rgb_t in_px, rd_px, rd_nb;
  logic [AW-1:0]    rd_addr_a, rd_addr_b, wr_addr;
  logic             wr_en;
  logic [CNT_W-1:0] q_count, q_delay;
  logic             take_ok, in_acc;

  assign in_px.red   = in_if.red_in;
  assign in_px.green = in_if.green_in;
  assign in_px.blue  = in_if.blue_in;

  // Input stalls only when the compare stage is full and the result is stuck.
  assign in_if.ready = take_ok;
  assign in_acc      = in_if.valid && take_ok;

  ndedge_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Head/count/column bookkeeping; decides at accept time whether the beat
  // retires a pixel and where its neighbour comes from.
  ndedge_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .RING      (RING),
    .AW        (AW),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .acc       (in_acc),
    .func      (in_if.func),
    .px        (in_px),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .dec       (dec),
    .count     (q_count),
    .delay     (q_delay)
  );

  // Reads and the push of the same beat share one edge; the read sees the
  // old entry, so no forwarding path is needed.
  ndedge_ring #(
    .DEPTH (RING),
    .AW    (AW)
  ) u_ring (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_px),
    .rd_data_b (rd_nb),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_px)
  );

  ndedge_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (cfg.threshold),
    .acc       (in_acc),
    .dec       (dec),
    .rd_px     (rd_px),
    .rd_nb     (rd_nb),
    .take_ok   (take_ok),
    .res       (out_if)
  );

  // An empty queue never retires anything.
  `NDEDGE_ASSERT_SAME(a_empty_no_dec, in_acc && (q_count == '0), !dec.valid, "decision from empty queue")
  // A flush on an empty queue keeps it empty.
  `NDEDGE_ASSERT_NEXT(a_flush_empty, in_acc && (in_if.func == ndedge_pkg::FUNC_FLUSH) && (q_count == '0), q_count == '0, "flush filled queue")
  // A pixel short of its neighbour distance only grows the queue.
  `NDEDGE_ASSERT_NEXT(a_fill_grow, in_acc && (in_if.func == ndedge_pkg::FUNC_PIXEL) && (q_count < q_delay), q_count == $past(q_count) + CNT_W'(1), "queue fill count slip")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking bench for neighbour_difference_edge_detect: drives pixel and flush beats,
// sets the registers over APB and checks every edge decision against an in-bench queue model.
// Depends on ndedge_pkg, ndedge_pix_if, ndedge_res_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import ndedge_pkg::*;

  localparam int unsigned RING_DEPTH     = MAX_WIDTH_DEF + 1;
  localparam int unsigned RANDOM_PIXELS  = 150;
  localparam int unsigned SETTLE_CYCLES  = 4;     // result lags its beat by the ring read and result registers
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat and no APB access
  localparam int unsigned MISMATCH_SHOWN = 10;
  localparam logic [1:0]  DIR_SPARE      = 2'd3;  // unused code, behaves as below-right

  typedef struct packed {
    logic func;
    rgb_t px;
  } beat_t;

  typedef enum int {
    TRAFFIC_FULL,
    TRAFFIC_SEND_GAPS,
    TRAFFIC_RECV_STALLS,
    TRAFFIC_BOTH
  } traffic_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, buses
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ndedge_pix_if pix_bus ();
  ndedge_res_if res_bus ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  wire  [APB_DW-1:0] cfg_prdata;
  wire               cfg_pready;

  neighbour_difference_edge_detect u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (pix_bus),
    .out_if      (res_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Queue model: register copy plus the pixel ring, updated on every accepted
  // input beat. Decisions it produces wait in edge_verdicts in raster order.
  // ---------------------------------------------------------------------------
  logic [1:0]       cur_dir   = DIR_RST;
  logic [7:0]       cur_thr   = THR_RST;
  logic [IMG_W-1:0] cur_width = WIDTH_RST;

  rgb_t        ring_mem [RING_DEPTH];
  int unsigned queued   = 0;   // pixels waiting for their neighbour
  int unsigned head     = 0;   // ring slot of the oldest one
  logic [9:0]  oldest_col = '0;
  logic [9:0]  newest_col = '0;
  bit          edge_verdicts [$];

  // Widths below 2 act as 2, above MAX_WIDTH_DEF as MAX_WIDTH_DEF.
  function automatic int unsigned active_width();
    if (cur_width < 2) return 2;
    if (cur_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return cur_width;
  endfunction

  // How many pixels later the neighbour arrives.
  function automatic int unsigned neighbour_offset(int unsigned w);
    if (cur_dir == DIR_RIGHT) return 1;
    if (cur_dir == DIR_BELOW) return w;
    return w + 1;  // below-right and the spare code
  endfunction

  // Column counters wrap at the width, also when they already sit past it.
  function automatic logic [9:0] next_col(logic [9:0] c, int unsigned w);
    if (c + 1 >= w) return '0;
    return c + 10'd1;
  endfunction

  function automatic bit rises(logic [7:0] nb, logic [7:0] px);
    return (int'(nb) - int'(px)) > int'(cur_thr);
  endfunction

  function automatic void retire_oldest(bit nb_present, rgb_t nb, int unsigned w);
    rgb_t px       = ring_mem[head];
    bit   in_image = nb_present;
    bit   hit;
    // right and below-right have nothing past the last column
    if (cur_dir != DIR_BELOW && oldest_col + 1 >= w) in_image = 1'b0;
    hit = in_image && (rises(nb.red, px.red) || rises(nb.green, px.green) ||
                       rises(nb.blue, px.blue));
    edge_verdicts.push_back(hit);
    head   = (head + 1) % RING_DEPTH;
    queued = queued - 1;
    oldest_col = next_col(oldest_col, w);
  endfunction

  function automatic void advance_frame(logic func, rgb_t pix);
    int unsigned w = active_width();
    int unsigned d = neighbour_offset(w);
    if (func == FUNC_PIXEL) begin
      // neighbour is either already queued or the pixel arriving now
      if (queued + 1 > d)
        retire_oldest(1'b1, (d < queued) ? ring_mem[(head + d) % RING_DEPTH] : pix, w);
      if (queued < RING_DEPTH) begin
        ring_mem[(head + queued) % RING_DEPTH] = pix;
        queued = queued + 1;
      end
      if (queued == 1) oldest_col = newest_col;
      newest_col = next_col(newest_col, w);
    end else begin
      // flush: drain one pixel, neighbour only if it is still queued
      if (queued > 0)
        retire_oldest(d < queued, (d < queued) ? ring_mem[(head + d) % RING_DEPTH] : '0, w);
      if (queued == 0) begin
        oldest_col = '0;
        newest_col = '0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: all sampling at the rising edge. Register writes first, then the
  // input beat (model update), then the result beat (check against oldest).
  // ---------------------------------------------------------------------------
  bit          beat_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned verdicts_checked = 0;
  int unsigned edges_seen = 0;
  int unsigned pixel_beats = 0;
  int unsigned flush_beats = 0;
  int unsigned reg_writes = 0;

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= MISMATCH_SHOWN) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin : watch_ports
    bit want;
    if (!rst_n) begin
      beat_taken = 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_DIRECTION: cur_dir   = cfg_pwdata[1:0];
          REG_THRESHOLD: cur_thr   = cfg_pwdata[7:0];
          REG_WIDTH:     cur_width = cfg_pwdata[IMG_W-1:0];
          default: ;
        endcase
        reg_writes++;
      end

      beat_taken = pix_bus.valid && pix_bus.ready;
      if (beat_taken) begin
        advance_frame(pix_bus.func, {pix_bus.red_in, pix_bus.green_in, pix_bus.blue_in});
        if (pix_bus.func == FUNC_PIXEL) pixel_beats++;
        else flush_beats++;
      end

      if (res_bus.valid && res_bus.ready) begin
        if (edge_verdicts.size() == 0) begin
          log_mismatch($sformatf("result beat %0b with no decision pending",
                                 res_bus.edge_found));
        end else begin
          want = edge_verdicts.pop_front();
          if (res_bus.edge_found !== want)
            log_mismatch($sformatf("decision %0d: expected edge_found %0b, got %0b",
                                   verdicts_checked, want, res_bus.edge_found));
          edges_seen += want;
        end
        verdicts_checked++;
      end
    end
  end

  // Watchdog: too long without any beat or APB access means the block hung.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no traffic for %0d cycles, %0d decisions outstanding",
               $realtime, quiet_cycles, edge_verdicts.size());
      $display("CHECK FAILED");
      $finish;
    end else if (!rst_n || (pix_bus.valid && pix_bus.ready) ||
                 (res_bus.valid && res_bus.ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. Valid holds until the beat is
  // taken; the gap and stall rates come from the current traffic mode.
  // ---------------------------------------------------------------------------
  beat_t       pending_beats [$];
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  always @(negedge clk) begin : drive_beats
    beat_t nxt;
    if (rst_n) begin
      if (!pix_bus.valid || beat_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = pending_beats.pop_front();
          pix_bus.valid    <= 1'b1;
          pix_bus.func     <= nxt.func;
          pix_bus.red_in   <= nxt.px.red;
          pix_bus.green_in <= nxt.px.green;
          pix_bus.blue_in  <= nxt.px.blue;
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
      res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  rgb_t        last_pix = '0;
  int unsigned stim_pixels = 0;

  task automatic set_traffic(traffic_t mode);
    case (mode)
      TRAFFIC_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      TRAFFIC_SEND_GAPS:   begin send_gap_pct = 54; recv_stall_pct = 0;  end
      TRAFFIC_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 54; end
      default:             begin send_gap_pct = 9;  recv_stall_pct = 9;  end
    endcase
  endtask

  // APB write: setup cycle, access cycle, done when pready is seen high.
  task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mostly small steps from the previous pixel so differences land near the
  // threshold; now and then a fresh random color.
  function automatic logic [7:0] nudge(logic [7:0] c);
    int v = int'(c) + int'($urandom_range(0, 24)) - 12;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic rgb_t next_pixel();
    if ($urandom_range(0, 3) == 0) begin
      last_pix = 24'($urandom_range(0, 32'hFF_FFFF));
    end else begin
      last_pix.red   = nudge(last_pix.red);
      last_pix.green = nudge(last_pix.green);
      last_pix.blue  = nudge(last_pix.blue);
    end
    return last_pix;
  endfunction

  function automatic void queue_pixel(rgb_t p);
    pending_beats.push_back({FUNC_PIXEL, p});
    stim_pixels++;
  endfunction

  function automatic void queue_flushes(int unsigned n);
    repeat (n) pending_beats.push_back({FUNC_FLUSH, 24'h0});
  endfunction

  // Wait until every beat is taken and every decision checked, then give the
  // pipeline time to finish beats that produce nothing.
  task automatic drain_and_wait();
    do @(posedge clk);
    while (pending_beats.size() != 0 || pix_bus.valid || edge_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_idx;
    int unsigned first_random;
    int unsigned w;
    int unsigned d;
    int unsigned n_pix;

    rst_n            = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    pix_bus.valid    = 1'b0;
    pix_bus.func     = FUNC_PIXEL;
    pix_bus.red_in   = '0;
    pix_bus.green_in = '0;
    pix_bus.blue_in  = '0;
    res_bus.ready    = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Right neighbour, threshold 0, width 2: full-scale rise is an edge, a
    // fall is not, last column never is, a lone tail pixel drains clean and
    // flushes on an empty queue give nothing.
    set_traffic(TRAFFIC_FULL);
    write_reg(REG_DIRECTION, APB_DW'(DIR_RIGHT));
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_WIDTH, 2);
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h000000);
    queue_pixel(24'h000000);
    queue_flushes(3);
    drain_and_wait();

    // Below-right, threshold 254, width 1 (acts as 2): blue-only step of 255
    // against the pixel arriving now; the rest drain as last column / last row.
    write_reg(REG_DIRECTION, APB_DW'(DIR_BELOW_RIGHT));
    write_reg(REG_THRESHOLD, 254);
    write_reg(REG_WIDTH, 1);
    queue_pixel(24'h000000);
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h0000FF);
    queue_flushes(4);
    drain_and_wait();

    // Change mid-frame: five pixels queued for "below" at width 6, then switch
    // to right at width 3. The long queue drains one per beat and the column
    // counter, already past the new width, wraps.
    write_reg(REG_DIRECTION, APB_DW'(DIR_BELOW));
    write_reg(REG_THRESHOLD, 5);
    write_reg(REG_WIDTH, 6);
    repeat (5) queue_pixel(next_pixel());
    drain_and_wait();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_DIRECTION, APB_DW'(DIR_RIGHT));
    repeat (2) queue_pixel(next_pixel());
    queue_flushes(6);
    drain_and_wait();

    // Random phases: new settings and traffic mode each time, frames mostly
    // well formed (whole rows, optional partial row, drain), some ragged
    // mixes of pixels and flushes.
    phase_idx    = 0;
    first_random = stim_pixels;
    while (stim_pixels - first_random < RANDOM_PIXELS) begin
      set_traffic(traffic_t'(phase_idx % 4));
      if (phase_idx == 0 || $urandom_range(0, 3) != 0)
        write_reg(REG_DIRECTION, $urandom_range(0, 3));
      if (phase_idx == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_THRESHOLD, 0);
          1:       write_reg(REG_THRESHOLD, 255);
          2:       write_reg(REG_THRESHOLD, $urandom_range(0, 16));
          default: write_reg(REG_THRESHOLD, $urandom_range(0, 255));
        endcase
      end
      if (phase_idx == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0:       write_reg(REG_WIDTH, $urandom_range(0, 1));
          1, 2:    write_reg(REG_WIDTH, $urandom_range(9, 40));
          3:       write_reg(REG_WIDTH, $urandom_range(MAX_WIDTH_DEF + 1, 2047));
          default: write_reg(REG_WIDTH, $urandom_range(2, 8));
        endcase
      end
      w = active_width();
      d = neighbour_offset(w);

      repeat ($urandom_range(1, 3)) begin
        n_pix = 0;
        if ($urandom_range(0, 4) == 0) begin
          // ragged: flushes mid-frame, pixels continuing a draining queue
          repeat ($urandom_range(4, 24)) begin
            if ($urandom_range(0, 3) == 0) begin
              queue_flushes(1);
            end else begin
              queue_pixel(next_pixel());
              n_pix++;
            end
          end
          queue_flushes(((n_pix < d) ? n_pix : d) + 1);
        end else begin
          if (w > 64) begin
            n_pix = $urandom_range(5, 30);  // wide image: a short strip only
          end else begin
            n_pix = w * $urandom_range(1, 4);
            if ($urandom_range(0, 2) == 0) n_pix += $urandom_range(1, w - 1);
          end
          repeat (n_pix) queue_pixel(next_pixel());
          queue_flushes(((n_pix < d) ? n_pix : d) + $urandom_range(0, 2));
        end
      end
      drain_and_wait();
      phase_idx++;
    end

    // Widest image with the spare direction code: the queue fills the whole
    // ring before the first decision and stays full while pixels keep coming;
    // a few flushes then retire the head of the queue.
    set_traffic(traffic_t'(phase_idx % 4));
    write_reg(REG_DIRECTION, APB_DW'(DIR_SPARE));
    write_reg(REG_THRESHOLD, $urandom_range(0, 30));
    write_reg(REG_WIDTH, MAX_WIDTH_DEF);
    repeat (MAX_WIDTH_DEF + 5) queue_pixel(next_pixel());
    queue_flushes(4);
    drain_and_wait();

    if (edge_verdicts.size() != 0)
      log_mismatch($sformatf("%0d decisions never came out", edge_verdicts.size()));

    $display("Run: %0d pixel and %0d flush beats, %0d register writes, %0d random phases",
             pixel_beats, flush_beats, reg_writes, phase_idx);
    $display("Decisions checked: %0d (%0d edges), mismatches: %0d",
             verdicts_checked, edges_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
